[rtl/smc_pkg.sv]
// Shared types and constants for the sprite mask collision block.
// No dependencies; smc_if and the top level refer to this package by scope.
`default_nettype none

package smc_pkg;

  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned PIX_BITS    = 6;
  localparam int unsigned CFG_BITS    = 7;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_WR_FIRST  = 2'd0,
    OP_WR_SECOND = 2'd1,
    OP_CHECK     = 2'd2,
    OP_NOP       = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_WIDTH   = 2'd0,
    CFG_FIRST_HEIGHT  = 2'd1,
    CFG_SECOND_WIDTH  = 2'd2,
    CFG_SECOND_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_GEOM1,
    ST_GEOM2,
    ST_GEOM3,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/smc_if.sv]
// Request and response channel interfaces of the sprite mask collision block.
// Depends on smc_pkg for the fixed field widths.
`default_nettype none

interface smc_req_if #(
  parameter int COORD_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic [smc_pkg::OPCODE_BITS-1:0]   opcode;
  logic [smc_pkg::PIX_BITS-1:0]      pixel_col;
  logic [smc_pkg::PIX_BITS-1:0]      pixel_row;
  logic                              pixel_set;
  logic signed [COORD_BITS-1:0]      first_left;
  logic signed [COORD_BITS-1:0]      first_top;
  logic signed [COORD_BITS-1:0]      second_left;
  logic signed [COORD_BITS-1:0]      second_top;

  modport source (
    output valid, opcode, pixel_col, pixel_row, pixel_set,
           first_left, first_top, second_left, second_top,
    input  ready
  );

  modport sink (
    input  valid, opcode, pixel_col, pixel_row, pixel_set,
           first_left, first_top, second_left, second_top,
    output ready
  );
endinterface

interface smc_rsp_if;
  logic valid;
  logic ready;
  logic collided;

  modport source (output valid, collided, input ready);
  modport sink   (input valid, collided, output ready);
endinterface

`default_nettype wire

[rtl/smc_mask_ram.sv]
// One mask store: synchronous single-port-write, single-read row memory.
// Read data is registered. No dependencies.
`default_nettype none

module smc_mask_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/smc_window.sv]
// Two-stage registered intersection of the two sprite rectangles.
// Produces an empty flag, row/column offsets, overlap height and column mask. No dependencies.
`default_nettype none

module smc_window #(
  parameter int MASK_SIDE  = 64,
  parameter int COORD_BITS = 12
) (
  input  wire logic                              clk_i,
  input  wire logic signed [COORD_BITS-1:0]      ax_i,
  input  wire logic signed [COORD_BITS-1:0]      ay_i,
  input  wire logic signed [COORD_BITS-1:0]      bx_i,
  input  wire logic signed [COORD_BITS-1:0]      by_i,
  input  wire logic [$clog2(MASK_SIDE+1)-1:0]    aw_i,
  input  wire logic [$clog2(MASK_SIDE+1)-1:0]    ah_i,
  input  wire logic [$clog2(MASK_SIDE+1)-1:0]    bw_i,
  input  wire logic [$clog2(MASK_SIDE+1)-1:0]    bh_i,
  output      logic                              empty_o,
  output      logic [$clog2(MASK_SIDE)-1:0]      sa_o,
  output      logic [$clog2(MASK_SIDE)-1:0]      sb_o,
  output      logic [$clog2(MASK_SIDE)-1:0]      ra_o,
  output      logic [$clog2(MASK_SIDE)-1:0]      rb_o,
  output      logic [$clog2(MASK_SIDE+1)-1:0]    rows_o,
  output      logic [MASK_SIDE-1:0]              colmask_o
);

  localparam int CW = COORD_BITS + 2;
  localparam int AW = $clog2(MASK_SIDE);
  localparam int DW = $clog2(MASK_SIDE + 1);

  logic signed [CW-1:0] ax, ay, bx, by;
  logic signed [CW-1:0] aw, ah, bw, bh;
  logic signed [CW-1:0] ax1, ay1, bx1, by1;
  logic signed [CW-1:0] x0_d, y0_d, x1_d, y1_d;
  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic                 zero_d, zero_q;
  logic signed [CW-1:0] n_s, h_s;
  logic [MASK_SIDE-1:0] ones;

  assign ax = CW'(ax_i);
  assign ay = CW'(ay_i);
  assign bx = CW'(bx_i);
  assign by = CW'(by_i);
  assign aw = CW'(aw_i);
  assign ah = CW'(ah_i);
  assign bw = CW'(bw_i);
  assign bh = CW'(bh_i);
  assign ones = '1;

  always_comb begin
    ax1    = ax + aw;
    ay1    = ay + ah;
    bx1    = bx + bw;
    by1    = by + bh;
    x0_d   = (ax > bx) ? ax : bx;
    y0_d   = (ay > by) ? ay : by;
    x1_d   = (ax1 < bx1) ? ax1 : bx1;
    y1_d   = (ay1 < by1) ? ay1 : by1;
    zero_d = (aw_i == '0) || (ah_i == '0) || (bw_i == '0) || (bh_i == '0);
  end

  always_ff @(posedge clk_i) begin
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    zero_q <= zero_d;
  end

  assign n_s = x1_q - x0_q;
  assign h_s = y1_q - y0_q;

  always_ff @(posedge clk_i) begin
    empty_o   <= zero_q || n_s[CW-1] || (n_s == '0) || h_s[CW-1] || (h_s == '0);
    sa_o      <= AW'(x0_q - ax);
    sb_o      <= AW'(x0_q - bx);
    ra_o      <= AW'(y0_q - ay);
    rb_o      <= AW'(y0_q - by);
    rows_o    <= DW'(h_s);
    colmask_o <= ~(ones << DW'(n_s));
  end

endmodule

`default_nettype wire

[rtl/smc_row_match.sv]
// Aligns one row of each mask, ANDs them under the column mask and
// accumulates a sticky hit flag. No dependencies.
`default_nettype none

module smc_row_match #(
  parameter int MASK_SIDE = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clr_i,
  input  wire logic                         en_i,
  input  wire logic [MASK_SIDE-1:0]         row_a_i,
  input  wire logic [MASK_SIDE-1:0]         row_b_i,
  input  wire logic [$clog2(MASK_SIDE)-1:0] sa_i,
  input  wire logic [$clog2(MASK_SIDE)-1:0] sb_i,
  input  wire logic [MASK_SIDE-1:0]         colmask_i,
  output      logic                         hit_o
);

  logic hit_q, hit_d;
  logic row_hit;

  assign row_hit = |((row_a_i >> sa_i) & (row_b_i >> sb_i) & colmask_i);

  always_comb begin
    hit_d = hit_q;
    if (clr_i) begin
      hit_d = 1'b0;
    end else if (en_i) begin
      hit_d = hit_q | row_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

[rtl/sprite_mask_collision.sv]
// Sprite mask collision top level: control sequencer, size registers,
// two mask row memories, window and row match units.
// Depends on smc_pkg, smc_if, smc_mask_ram, smc_window, smc_row_match.
//
// Requests arrive on req_i (valid/ready). A mask bit write (opcode 0 or 1)
// reads the addressed row and writes it back modified. Opcode 3 and
// writes outside the store do nothing. A check (opcode 2) steps through
// GEOM1, GEOM2 and GEOM3 to intersect the rectangles, then reads one row
// of both masks per cycle through the memory read ports over the overlap
// height H; a DRAIN state lets the last memory read complete and the DONE
// state registers the result (an empty overlap goes from GEOM3 to DONE).
// The next request is taken once the block is back in IDLE.
// The single response (collided) sits in an output register on rsp_o; new
// requests, writes included, are taken while it waits. A stalled receiver
// only holds a finished check before its result can be registered.
// Size registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must do so only while idle, which the block does not enforce.
// Reset clears the size registers and control; the mask memories are
// not cleared and must be written before use.
`default_nettype none

module sprite_mask_collision #(
  parameter int MASK_SIDE  = 64,
  parameter int COORD_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  smc_req_if.sink                                 req_i,
  smc_rsp_if.source                               rsp_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [smc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [smc_pkg::CFG_BITS-1:0]       cfg_data_i
);

  localparam int AW = $clog2(MASK_SIDE);
  localparam int DW = $clog2(MASK_SIDE + 1);
  localparam int unsigned MS = MASK_SIDE;

  smc_pkg::state_e  state_q, state_d;
  smc_pkg::opcode_e op_in, op_q;

  logic [smc_pkg::CFG_BITS-1:0] aw_cfg_q, ah_cfg_q, bw_cfg_q, bh_cfg_q;
  logic [DW-1:0] aw_c, ah_c, bw_c, bh_c;

  logic [AW-1:0] row_q, col_q;
  logic          bit_q;
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;

  logic          accept, in_rng;
  logic [AW-1:0] k_q, k_d;
  logic          rd_vld_q, rd_vld_d;
  logic          out_vld_q, out_vld_d, out_col_q, out_col_d;
  logic          out_free;

  logic          re, we_a, we_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [MASK_SIDE-1:0] rdata_a, rdata_b, wr_row;

  logic          empty;
  logic [AW-1:0] sa, sb, ra, rb;
  logic [DW-1:0] rows;
  logic [MASK_SIDE-1:0] colmask;
  logic          hit;

  function automatic logic [DW-1:0] clamp_side(input logic [smc_pkg::CFG_BITS-1:0] d);
    return (32'(d) > MS) ? DW'(MS) : DW'(d);
  endfunction

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_cfg_q <= '0;
      ah_cfg_q <= '0;
      bw_cfg_q <= '0;
      bh_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smc_pkg::CFG_FIRST_WIDTH:   aw_cfg_q <= cfg_data_i;
        smc_pkg::CFG_FIRST_HEIGHT:  ah_cfg_q <= cfg_data_i;
        smc_pkg::CFG_SECOND_WIDTH:  bw_cfg_q <= cfg_data_i;
        smc_pkg::CFG_SECOND_HEIGHT: bh_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign aw_c = clamp_side(aw_cfg_q);
  assign ah_c = clamp_side(ah_cfg_q);
  assign bw_c = clamp_side(bw_cfg_q);
  assign bh_c = clamp_side(bh_cfg_q);

  assign req_i.ready = (state_q == smc_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign op_in       = smc_pkg::opcode_e'(req_i.opcode);
  assign in_rng      = (32'(req_i.pixel_row) < MS) && (32'(req_i.pixel_col) < MS);
  assign out_free    = !out_vld_q || rsp_o.ready;

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_in;
      row_q <= AW'(req_i.pixel_row);
      col_q <= AW'(req_i.pixel_col);
      bit_q <= req_i.pixel_set;
      ax_q  <= req_i.first_left;
      ay_q  <= req_i.first_top;
      bx_q  <= req_i.second_left;
      by_q  <= req_i.second_top;
    end
  end

  always_comb begin
    wr_row = (op_q == smc_pkg::OP_WR_FIRST) ? rdata_a : rdata_b;
    wr_row[col_q] = bit_q;
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    rd_vld_d  = 1'b0;
    re        = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    raddr_a   = AW'(req_i.pixel_row);
    raddr_b   = AW'(req_i.pixel_row);
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_col_d = out_col_q;
    case (state_q)
      smc_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_in)
            smc_pkg::OP_WR_FIRST, smc_pkg::OP_WR_SECOND: begin
              if (in_rng) begin
                re      = 1'b1;
                state_d = smc_pkg::ST_WRITE;
              end
            end
            smc_pkg::OP_CHECK: state_d = smc_pkg::ST_GEOM1;
            default: ;
          endcase
        end
      end
      smc_pkg::ST_WRITE: begin
        we_a    = (op_q == smc_pkg::OP_WR_FIRST);
        we_b    = (op_q == smc_pkg::OP_WR_SECOND);
        state_d = smc_pkg::ST_IDLE;
      end
      smc_pkg::ST_GEOM1: state_d = smc_pkg::ST_GEOM2;
      smc_pkg::ST_GEOM2: state_d = smc_pkg::ST_GEOM3;
      smc_pkg::ST_GEOM3: begin
        k_d     = '0;
        state_d = empty ? smc_pkg::ST_DONE : smc_pkg::ST_SCAN;
      end
      smc_pkg::ST_SCAN: begin
        re       = 1'b1;
        rd_vld_d = 1'b1;
        raddr_a  = ra + k_q;
        raddr_b  = rb + k_q;
        k_d      = k_q + AW'(1);
        if ((DW'(k_q) + DW'(1)) == rows) begin
          state_d = smc_pkg::ST_DRAIN;
        end
      end
      smc_pkg::ST_DRAIN: state_d = smc_pkg::ST_DONE;
      smc_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_col_d = hit;
          state_d   = smc_pkg::ST_IDLE;
        end
      end
      default: state_d = smc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smc_pkg::ST_IDLE;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_col_q <= out_col_d;
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.collided = out_col_q;

  smc_mask_ram #(
    .WIDTH (MASK_SIDE),
    .DEPTH (MASK_SIDE)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (row_q),
    .wdata_i (wr_row),
    .re_i    (re),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  smc_mask_ram #(
    .WIDTH (MASK_SIDE),
    .DEPTH (MASK_SIDE)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (row_q),
    .wdata_i (wr_row),
    .re_i    (re),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  smc_window #(
    .MASK_SIDE  (MASK_SIDE),
    .COORD_BITS (COORD_BITS)
  ) u_window (
    .clk_i     (clk_i),
    .ax_i      (ax_q),
    .ay_i      (ay_q),
    .bx_i      (bx_q),
    .by_i      (by_q),
    .aw_i      (aw_c),
    .ah_i      (ah_c),
    .bw_i      (bw_c),
    .bh_i      (bh_c),
    .empty_o   (empty),
    .sa_o      (sa),
    .sb_o      (sb),
    .ra_o      (ra),
    .rb_o      (rb),
    .rows_o    (rows),
    .colmask_o (colmask)
  );

  smc_row_match #(
    .MASK_SIDE (MASK_SIDE)
  ) u_row_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (state_q == smc_pkg::ST_GEOM2),
    .en_i      (rd_vld_q),
    .row_a_i   (rdata_a),
    .row_b_i   (rdata_b),
    .sa_i      (sa),
    .sb_i      (sb),
    .colmask_i (colmask),
    .hit_o     (hit)
  );

endmodule

`default_nettype wire
